// File: rtl/ispf_pkg.sv
// ---------------------------------------------------------------------------
// ispf_pkg
// Shared constants for the inverse-square pair force pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package ispf_pkg;

  localparam int ISPF_FRAC_BITS = 16;
  localparam int DATA_W         = 32;
  localparam int IN_TDATA_W     = 8 * DATA_W;
  localparam int OUT_TDATA_W    = 4 * DATA_W;
  localparam int OUT_TUSER_W    = 2;

  // m_tuser bit positions
  localparam int USER_OVERLAP   = 0;
  localparam int USER_SATURATED = 1;

  // bit-products allowed per multiplier stage (about 32x32)
  localparam int MUL_BUDGET     = 1024;

  // divider: quotient bits kept below the saturation limit, plus check and round stages
  localparam int QUO_W          = 32;
  localparam int DIV_LAT        = QUO_W + 2;

endpackage

`default_nettype wire

// File: rtl/ispf_mul.sv
// ---------------------------------------------------------------------------
// ispf_mul
// Pipelined unsigned multiplier: one CH-bit slice of b per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ispf_mul #(
  parameter int A_W   = 32,
  parameter int B_W   = 32,
  parameter int CH    = 32,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  input  logic [TAG_W-1:0]   tag_in,
  output logic [A_W+B_W-1:0] p,
  output logic [TAG_W-1:0]   tag_out
);

  localparam int NS   = (B_W + CH - 1) / CH;
  localparam int BP_W = NS * CH;
  localparam int P_W  = A_W + B_W;

  logic [A_W-1:0]   a_q   [NS];
  logic [BP_W-1:0]  b_q   [NS];
  logic [P_W-1:0]   acc_q [NS];
  logic [TAG_W-1:0] tag_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [A_W-1:0]    a_i;
    logic [BP_W-1:0]   b_i;
    logic [P_W-1:0]    acc_i;
    logic [TAG_W-1:0]  t_i;
    logic [A_W+CH-1:0] pp;

    if (k == 0) begin : g_first
      assign a_i   = a;
      assign b_i   = BP_W'(b);
      assign acc_i = '0;
      assign t_i   = tag_in;
    end else begin : g_next
      assign a_i   = a_q[k-1];
      assign b_i   = b_q[k-1];
      assign acc_i = acc_q[k-1];
      assign t_i   = tag_q[k-1];
    end

    assign pp = a_i * b_i[k*CH +: CH];

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k]   <= a_i;
        b_q[k]   <= b_i;
        acc_q[k] <= acc_i + (P_W'(pp) << (k * CH));
        tag_q[k] <= t_i;
      end
    end
  end

  assign p       = acc_q[NS-1];
  assign tag_out = tag_q[NS-1];

endmodule

`default_nettype wire

// File: rtl/ispf_sqrt.sv
// ---------------------------------------------------------------------------
// ispf_sqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ispf_sqrt #(
  parameter int X_W   = 98,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [X_W-1:0]   x,
  input  logic [TAG_W-1:0] tag_in,
  output logic [X_W/2-1:0] root,
  output logic [TAG_W-1:0] tag_out
);

  localparam int RW  = X_W / 2;
  localparam int R_W = RW + 2;

  logic [X_W-1:0]   x_q    [RW];
  logic [R_W-1:0]   rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [TAG_W-1:0] tag_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [X_W-1:0]   x_i;
    logic [R_W-1:0]   rem_i;
    logic [RW-1:0]    root_i;
    logic [TAG_W-1:0] t_i;
    logic [R_W+1:0]   rs;
    logic [R_W+1:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign x_i    = x;
      assign rem_i  = '0;
      assign root_i = '0;
      assign t_i    = tag_in;
    end else begin : g_next
      assign x_i    = x_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign t_i    = tag_q[k-1];
    end

    // bring down the next two bits, try (4*root + 1)
    assign rs    = {rem_i, x_i[X_W-1 -: 2]};
    assign trial = (R_W+2)'({root_i, 2'b01});
    assign ge    = (rs >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[k]    <= x_i << 2;
        rem_q[k]  <= ge ? R_W'(rs - trial) : R_W'(rs);
        root_q[k] <= {root_i[RW-2:0], ge};
        tag_q[k]  <= t_i;
      end
    end
  end

  assign root    = root_q[RW-1];
  assign tag_out = tag_q[RW-1];

endmodule

`default_nettype wire

// File: rtl/ispf_div.sv
// ---------------------------------------------------------------------------
// ispf_div
// Pipelined restoring divider with overflow check and round-half-up.
// Returns a 33-bit rounded quotient and a flag for quotients >= 2^32.
// ---------------------------------------------------------------------------
`default_nettype none

module ispf_div
  import ispf_pkg::*;
#(
  parameter int N_W   = 160,
  parameter int D_W   = 144,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [N_W-1:0]   n,
  input  logic [D_W-1:0]   d,
  input  logic [TAG_W-1:0] tag_in,
  output logic [QUO_W:0]   q,
  output logic             big,
  output logic [TAG_W-1:0] tag_out
);

  localparam int H_W   = N_W - QUO_W;
  localparam int CMP_W = (H_W > D_W) ? H_W : D_W;

  logic [D_W-1:0]   d_q   [QUO_W+1];
  logic [D_W-1:0]   r_q   [QUO_W+1];
  logic [QUO_W-1:0] lo_q  [QUO_W+1];
  logic [QUO_W-1:0] q_q   [QUO_W+1];
  logic             big_q [QUO_W+1];
  logic [TAG_W-1:0] tag_q [QUO_W+1];

  logic [H_W-1:0] nhi;
  assign nhi = n[N_W-1:QUO_W];

  // quotient of 2^32 or more saturates anyway; else the upper part is already the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0]   <= d;
      r_q[0]   <= D_W'(nhi);
      lo_q[0]  <= n[QUO_W-1:0];
      q_q[0]   <= '0;
      big_q[0] <= (CMP_W'(nhi) >= CMP_W'(d));
      tag_q[0] <= tag_in;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [D_W:0] rs;
    logic [D_W:0] dx;
    logic         ge;

    assign rs = {r_q[k-1], lo_q[k-1][QUO_W-1]};
    assign dx = {1'b0, d_q[k-1]};
    assign ge = (rs >= dx);

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[k]   <= d_q[k-1];
        r_q[k]   <= ge ? D_W'(rs - dx) : D_W'(rs);
        lo_q[k]  <= lo_q[k-1] << 1;
        q_q[k]   <= {q_q[k-1][QUO_W-2:0], ge};
        big_q[k] <= big_q[k-1];
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  logic up;
  assign up = ({r_q[QUO_W], 1'b0} >= {1'b0, d_q[QUO_W]});

  always_ff @(posedge clk) begin
    if (en) begin
      q       <= {1'b0, q_q[QUO_W]} + (QUO_W+1)'(up);
      big     <= big_q[QUO_W];
      tag_out <= tag_q[QUO_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/inverse_square_pair_force_top.sv
// ---------------------------------------------------------------------------
// inverse_square_pair_force_top
// Pair force and potential, G*q1*q2 inverse-square law, Q16.16 in and out.
// ---------------------------------------------------------------------------
//  port group   dir  width  contents
//  s_*          in   256    one particle pair per item
//  m_*          out  128+2  forces, potential, overlap/saturated flags
//  cfg_*        in   32     coupling G
//
//  One item per cycle while the output is not stalled, fully pipelined. The
//  one-bit-per-stage square root (ROOT_W = 33 + FRAC_BITS root bits) and the
//  dividers make up most of the pipeline depth.
//  Reset clears the valid pipeline and sets G to 1.0.
//  A stalled output freezes the whole pipeline; s_tready = !m_tvalid || m_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module inverse_square_pair_force_top
  import ispf_pkg::*;
#(
  parameter int FRAC_BITS = ISPF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, first_charge, second_charge
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // force_x, force_y, force_z, potential
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // overlap, saturated
  output logic [OUT_TUSER_W-1:0] m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [DATA_W-1:0]      cfg_data
);

  localparam int KM_W   = 3 * DATA_W;
  localparam int P1_W   = 2 * DATA_W;
  localparam int SQ_W   = 2 * DATA_W;
  localparam int S_W    = SQ_W + 2;
  localparam int X_W    = S_W + 2 * FRAC_BITS;
  localparam int ROOT_W = X_W / 2;
  localparam int PG_W   = KM_W + ROOT_W;
  localparam int N_W    = PG_W + FRAC_BITS;

  localparam int CH1 = MUL_BUDGET / DATA_W;
  localparam int NS1 = (DATA_W + CH1 - 1) / CH1;
  localparam int CH2 = MUL_BUDGET / P1_W;
  localparam int NS2 = (DATA_W + CH2 - 1) / CH2;
  localparam int NSS = NS1;
  localparam int CHG = MUL_BUDGET / KM_W;
  localparam int NSG = (ROOT_W + CHG - 1) / CHG;
  localparam int LAT = 1 + NS1 + NS2 + NSS + 1 + ROOT_W + NSG + DIV_LAT + 1;

  localparam logic [DATA_W-1:0] COUPLING_RST = DATA_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic                   ovl;
    logic                   kneg;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] dm;
  } geo_t;

  typedef struct packed {
    logic [DATA_W-1:0] q2m;
    geo_t              geo;
  } m1_tag_t;

  typedef struct packed {
    logic [S_W-1:0]  s;
    logic [KM_W-1:0] kmag;
    geo_t            geo;
  } rt_tag_t;

  typedef struct packed {
    logic [KM_W-1:0]   kmag;
    logic [ROOT_W-1:0] dq;
    logic              kneg;
    logic              ovl;
  } den_tag_t;

  typedef struct packed {
    logic kneg;
    logic ovl;
  } pot_tag_t;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  // {clipped, value}
  function automatic logic [DATA_W:0] sat_res(input logic [DATA_W:0] q, input logic big,
                                              input logic neg);
    logic [DATA_W:0] lim;
    logic [DATA_W:0] v;
    logic            f;
    lim = neg ? {2'b01, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
    f   = big || (q > lim);
    v   = f ? lim : q;
    return {f, neg ? (~v[DATA_W-1:0] + DATA_W'(1)) : v[DATA_W-1:0]};
  endfunction

  logic           en;
  logic [LAT-1:0] vld;
  logic [DATA_W-1:0] coupling;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling <= COUPLING_RST;
    end else if (cfg_valid && cfg_ready) begin
      coupling <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // ---- stage 0: differences and magnitudes
  geo_t              geo_next;
  geo_t              s0_geo;
  logic [DATA_W-1:0] s0_gm;
  logic [DATA_W-1:0] s0_q1m;
  logic [DATA_W-1:0] s0_q2m;

  always_comb begin
    logic [DATA_W-1:0] fa;
    logic [DATA_W-1:0] sb;
    logic [DATA_W:0]   dr;
    logic [DATA_W:0]   dmag;
    for (int i = 0; i < 3; i++) begin
      fa = s_tdata[i*DATA_W +: DATA_W];
      sb = s_tdata[(3+i)*DATA_W +: DATA_W];
      dr = {sb[DATA_W-1], sb} - {fa[DATA_W-1], fa};
      dmag = dr[DATA_W] ? (~dr + (DATA_W+1)'(1)) : dr;
      geo_next.neg[i] = dr[DATA_W];
      geo_next.dm[i]  = dmag[DATA_W-1:0];
    end
    geo_next.kneg = coupling[DATA_W-1] ^ s_tdata[7*DATA_W-1] ^ s_tdata[8*DATA_W-1];
    geo_next.ovl  = (geo_next.dm == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_geo <= geo_next;
      s0_gm  <= mag32(coupling);
      s0_q1m <= mag32(s_tdata[6*DATA_W +: DATA_W]);
      s0_q2m <= mag32(s_tdata[7*DATA_W +: DATA_W]);
    end
  end

  // ---- coupling product K = |G|*|q1|*|q2|
  logic [P1_W-1:0]   m1_p;
  m1_tag_t           m1_tag;
  logic [KM_W-1:0]   m2_kmag;
  geo_t              m2_geo;

  ispf_mul #(.A_W(DATA_W), .B_W(DATA_W), .CH(CH1), .TAG_W($bits(m1_tag_t))) u_mul_gq (
    .clk(clk), .en(en), .a(s0_gm), .b(s0_q1m),
    .tag_in({s0_q2m, s0_geo}), .p(m1_p), .tag_out(m1_tag)
  );

  ispf_mul #(.A_W(P1_W), .B_W(DATA_W), .CH(CH2), .TAG_W($bits(geo_t))) u_mul_k (
    .clk(clk), .en(en), .a(m1_p), .b(m1_tag.q2m),
    .tag_in(m1_tag.geo), .p(m2_kmag), .tag_out(m2_geo)
  );

  // ---- squared distance
  logic [SQ_W-1:0]           sq0;
  logic [SQ_W-1:0]           sq1;
  logic [SQ_W-1:0]           sq2;
  logic [KM_W-1:0]           sq_kmag;
  logic [2:0][DATA_W-1:0]    sq_dm;
  logic [4:0]                sq_flags;

  ispf_mul #(.A_W(DATA_W), .B_W(DATA_W), .CH(CH1), .TAG_W(KM_W)) u_sq_x (
    .clk(clk), .en(en), .a(m2_geo.dm[0]), .b(m2_geo.dm[0]),
    .tag_in(m2_kmag), .p(sq0), .tag_out(sq_kmag)
  );

  ispf_mul #(.A_W(DATA_W), .B_W(DATA_W), .CH(CH1), .TAG_W(3*DATA_W)) u_sq_y (
    .clk(clk), .en(en), .a(m2_geo.dm[1]), .b(m2_geo.dm[1]),
    .tag_in(m2_geo.dm), .p(sq1), .tag_out(sq_dm)
  );

  ispf_mul #(.A_W(DATA_W), .B_W(DATA_W), .CH(CH1), .TAG_W(5)) u_sq_z (
    .clk(clk), .en(en), .a(m2_geo.dm[2]), .b(m2_geo.dm[2]),
    .tag_in({m2_geo.ovl, m2_geo.kneg, m2_geo.neg}), .p(sq2), .tag_out(sq_flags)
  );

  rt_tag_t sum_q;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q.s        <= S_W'(sq0) + S_W'(sq1) + S_W'(sq2);
      sum_q.kmag     <= sq_kmag;
      sum_q.geo.dm   <= sq_dm;
      sum_q.geo.neg  <= sq_flags[2:0];
      sum_q.geo.kneg <= sq_flags[3];
      sum_q.geo.ovl  <= sq_flags[4];
    end
  end

  // ---- distance dq = floor(sqrt(s << 2F)), 2F fraction bits
  logic [ROOT_W-1:0] dq;
  rt_tag_t           rt_tag;

  ispf_sqrt #(.X_W(X_W), .TAG_W($bits(rt_tag_t))) u_sqrt (
    .clk(clk), .en(en), .x({sum_q.s, {(2*FRAC_BITS){1'b0}}}),
    .tag_in(sum_q), .root(dq), .tag_out(rt_tag)
  );

  // ---- denominator s*dq and numerators |dr_i|*K
  logic [PG_W-1:0] den;
  den_tag_t        den_tag;
  logic [PG_W-1:0] num [3];
  logic [2:0]      num_neg;

  ispf_mul #(.A_W(KM_W), .B_W(ROOT_W), .CH(CHG), .TAG_W($bits(den_tag_t))) u_mul_den (
    .clk(clk), .en(en), .a(KM_W'(rt_tag.s)), .b(dq),
    .tag_in({rt_tag.kmag, dq, rt_tag.geo.kneg, rt_tag.geo.ovl}),
    .p(den), .tag_out(den_tag)
  );

  for (genvar i = 0; i < 3; i++) begin : g_num
    ispf_mul #(.A_W(KM_W), .B_W(ROOT_W), .CH(CHG), .TAG_W(1)) u_mul_num (
      .clk(clk), .en(en), .a(rt_tag.kmag), .b(ROOT_W'(rt_tag.geo.dm[i])),
      .tag_in(rt_tag.geo.neg[i]), .p(num[i]), .tag_out(num_neg[i])
    );
  end

  // ---- divisions
  logic [QUO_W:0] pot_q;
  logic           pot_big;
  pot_tag_t       pot_tag;
  logic [QUO_W:0] frc_q   [3];
  logic [2:0]     frc_big;
  logic [2:0]     frc_neg;

  ispf_div #(.N_W(N_W), .D_W(PG_W), .TAG_W($bits(pot_tag_t))) u_div_pot (
    .clk(clk), .en(en), .n(N_W'(den_tag.kmag)), .d(PG_W'(den_tag.dq)),
    .tag_in({den_tag.kneg, den_tag.ovl}), .q(pot_q), .big(pot_big), .tag_out(pot_tag)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    ispf_div #(.N_W(N_W), .D_W(PG_W), .TAG_W(1)) u_div_frc (
      .clk(clk), .en(en), .n({num[i], {FRAC_BITS{1'b0}}}), .d(den),
      .tag_in(num_neg[i]), .q(frc_q[i]), .big(frc_big[i]), .tag_out(frc_neg[i])
    );
  end

  // ---- output register
  logic [OUT_TDATA_W-1:0] out_data_next;
  logic [OUT_TUSER_W-1:0] out_user_next;
  logic [OUT_TDATA_W-1:0] out_data;
  logic [OUT_TUSER_W-1:0] out_user;

  always_comb begin
    logic [DATA_W:0] r;
    logic            clip;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // force opposes dr: negative when sign(dr) matches sign(K)
      r = sat_res(frc_q[i], frc_big[i], frc_neg[i] == pot_tag.kneg);
      out_data_next[i*DATA_W +: DATA_W] = r[DATA_W-1:0];
      clip = clip | r[DATA_W];
    end
    r = sat_res(pot_q, pot_big, pot_tag.kneg);
    out_data_next[3*DATA_W +: DATA_W] = r[DATA_W-1:0];
    clip = clip | r[DATA_W];
    out_user_next[USER_OVERLAP]   = pot_tag.ovl;
    out_user_next[USER_SATURATED] = clip;
    if (pot_tag.ovl) begin
      out_data_next                 = '0;
      out_user_next[USER_SATURATED] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_data_next;
      out_user <= out_user_next;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_user;

  // ---- checks
  a_stall_only_on_output : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  a_overlap_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_OVERLAP]) |->
      (m_tdata == '0 && !m_tuser[USER_SATURATED]))
    else $error("overlap item with nonzero results");

  a_sat_extreme : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_SATURATED]) |->
      (m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
       m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000 ||
       m_tdata[95:64] == 32'h7fff_ffff || m_tdata[95:64] == 32'h8000_0000 ||
       m_tdata[127:96] == 32'h7fff_ffff || m_tdata[127:96] == 32'h8000_0000))
    else $error("saturated item with no clipped field");

  a_valid_advance : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted item not entered into pipeline");

endmodule

`default_nettype wire
